[rtl/core/i64d_pkg.sv]
`timescale 1ns / 1ps
package i64d_pkg;

  // division mode carried in the request opcode
  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic load;   // take fresh operands
    logic shift;  // resolve one quotient bit
  } cell_ctrl_t;

endpackage

[rtl/core/i64d_req_if.sv]
`timescale 1ns / 1ps
interface i64d_req_if #(
  parameter int W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] dividend;
  logic [W-1:0] divisor;
  logic         opcode;

  modport source (output valid, output dividend, output divisor, output opcode, input ready);
  modport sink   (input valid, input dividend, input divisor, input opcode, output ready);
endinterface

[rtl/core/i64d_rsp_if.sv]
`timescale 1ns / 1ps
interface i64d_rsp_if #(
  parameter int W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] quotient;
  logic [W-1:0] remainder;
  logic         divide_by_zero;

  modport source (output valid, output quotient, output remainder, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                  output ready);
endinterface

[rtl/core/i64d_cell.sv]
`timescale 1ns / 1ps
module i64d_cell (
  input  logic                clk,
  input  i64d_pkg::cell_ctrl_t ctrl,
  input  logic                ld_q,   // dividend bit on load
  input  logic                ld_d,   // divisor bit on load
  input  logic                r_in,   // shifted remainder bit from lower neighbour
  input  logic                q_in,   // quotient/dividend bit from lower neighbour
  input  logic                b_in,   // borrow from lower neighbour
  input  logic                ge,     // row-wide subtract decision
  output logic                r_out,
  output logic                q_out,
  output logic                b_out
);
  import i64d_pkg::*;

  logic r_r, r_nxt;
  logic q_r, q_nxt;
  logic d_r, d_nxt;
  logic diff;

  // one bit of the trial subtract {r, n} - d
  assign diff  = r_in ^ d_r ^ b_in;
  assign b_out = (~r_in & d_r) | (~(r_in ^ d_r) & b_in);

  always_comb begin
    r_nxt = r_r;
    q_nxt = q_r;
    d_nxt = d_r;
    if (ctrl.load) begin
      r_nxt = 1'b0;
      q_nxt = ld_q;
      d_nxt = ld_d;
    end else if (ctrl.shift) begin
      r_nxt = ge ? diff : r_in;
      q_nxt = q_in;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
  end

  assign r_out = r_r;
  assign q_out = q_r;
endmodule

[rtl/core/int64_divider.sv]
// a taken request passes through operand prep, the iterations and the sign fix
//   into the output register; the row of bit cells resolves one quotient bit per
//   cycle; a zero divisor skips the iterations; no new request is taken until idle
// the output register frees the result side, so a finished result may wait for a taker
// reset: rst_n synchronous active low, clears sequencer and output valid; data is not reset
`timescale 1ns / 1ps
module int64_divider #(
  parameter int DATA_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  i64d_req_if.sink     in_chan,
  i64d_rsp_if.source   out_chan
);
  import i64d_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_ITER = 2'd2;
  localparam logic [1:0] S_FIX  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // captured request
  logic [DATA_WIDTH-1:0] n_raw_r, n_raw_nxt;
  logic [DATA_WIDTH-1:0] d_raw_r, d_raw_nxt;
  logic                  signed_r, signed_nxt;

  // sign and zero flags worked out during prep
  logic                  n_neg_r, n_neg_nxt;
  logic                  d_neg_r, d_neg_nxt;
  logic                  dz_r, dz_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_q_r, out_q_nxt;
  logic [DATA_WIDTH-1:0] out_rem_r, out_rem_nxt;
  logic                  out_dz_r, out_dz_nxt;

  // cell row wiring
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] ld_n, ld_d;
  logic [DATA_WIDTH-1:0] r_vec, q_vec, b_vec;
  logic                  ge;

  logic                  in_fire;
  logic                  fix_fire;
  logic                  n_neg_now, d_neg_now;
  logic [DATA_WIDTH-1:0] q_fixed, r_fixed;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  // result moves into the output register once that register is free
  assign fix_fire      = (state_r == S_FIX) && (!out_valid_r || out_chan.ready);

  // operand magnitudes for the cell row
  assign n_neg_now = signed_r && n_raw_r[DATA_WIDTH-1];
  assign d_neg_now = signed_r && d_raw_r[DATA_WIDTH-1];
  assign ld_n      = n_neg_now ? (DATA_WIDTH'(0) - n_raw_r) : n_raw_r;
  assign ld_d      = d_neg_now ? (DATA_WIDTH'(0) - d_raw_r) : d_raw_r;

  assign ctrl.load  = (state_r == S_PREP);
  assign ctrl.shift = (state_r == S_ITER);

  // subtract when the shifted remainder, with the bit carried out of the top, covers d
  assign ge = r_vec[DATA_WIDTH-1] | ~b_vec[DATA_WIDTH-1];

  // the row: cell i holds remainder bit i, dividend/quotient bit i and divisor bit i
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    if (i == 0) begin : g_lsb
      i64d_cell u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .ld_q  (ld_n[i]),
        .ld_d  (ld_d[i]),
        .r_in  (q_vec[DATA_WIDTH-1]),  // next dividend bit enters the remainder
        .q_in  (ge),                   // new quotient bit enters at the bottom
        .b_in  (1'b0),
        .ge    (ge),
        .r_out (r_vec[i]),
        .q_out (q_vec[i]),
        .b_out (b_vec[i])
      );
    end else begin : g_upper
      i64d_cell u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .ld_q  (ld_n[i]),
        .ld_d  (ld_d[i]),
        .r_in  (r_vec[i-1]),
        .q_in  (q_vec[i-1]),
        .b_in  (b_vec[i-1]),
        .ge    (ge),
        .r_out (r_vec[i]),
        .q_out (q_vec[i]),
        .b_out (b_vec[i])
      );
    end
  end

  // sign correction; zero divisor gives all ones and the dividend back
  assign q_fixed = dz_r ? '1 :
                   ((n_neg_r ^ d_neg_r) ? (DATA_WIDTH'(0) - q_vec) : q_vec);
  assign r_fixed = dz_r ? n_raw_r :
                   (n_neg_r ? (DATA_WIDTH'(0) - r_vec) : r_vec);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_raw_nxt  = n_raw_r;
    d_raw_nxt  = d_raw_r;
    signed_nxt = signed_r;
    n_neg_nxt  = n_neg_r;
    d_neg_nxt  = d_neg_r;
    dz_nxt     = dz_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          n_raw_nxt  = in_chan.dividend;
          d_raw_nxt  = in_chan.divisor;
          signed_nxt = (in_chan.opcode == OP_SIGNED);
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        n_neg_nxt = n_neg_now;
        d_neg_nxt = d_neg_now;
        dz_nxt    = (d_raw_r == '0);
        cnt_nxt   = '0;
        // zero divisor skips the iterations
        state_nxt = (d_raw_r == '0) ? S_FIX : S_ITER;
      end
      S_ITER: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (fix_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_q_nxt   = out_q_r;
    out_rem_nxt = out_rem_r;
    out_dz_nxt  = out_dz_r;
    priority if (fix_fire) begin
      out_valid_nxt = 1'b1;
      out_q_nxt     = q_fixed;
      out_rem_nxt   = r_fixed;
      out_dz_nxt    = dz_r;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    n_raw_r   <= n_raw_nxt;
    d_raw_r   <= d_raw_nxt;
    signed_r  <= signed_nxt;
    n_neg_r   <= n_neg_nxt;
    d_neg_r   <= d_neg_nxt;
    dz_r      <= dz_nxt;
    out_q_r   <= out_q_nxt;
    out_rem_r <= out_rem_nxt;
    out_dz_r  <= out_dz_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.quotient       = out_q_r;
  assign out_chan.remainder      = out_rem_r;
  assign out_chan.divide_by_zero = out_dz_r;

  // a taken request always goes to operand prep next
  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_PREP))
    else $error("request not followed by prep");

  // the sign fix is reached from the iterations only after the last quotient bit
  a_full_iterations: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX && $past(state_r) == S_ITER) |-> ($past(cnt_r) == CNT_LAST))
    else $error("iterations cut short");

  // a result appears only out of the sign-fix step
  a_valid_from_fix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIX))
    else $error("result raised outside sign fix");

  // zero divisor reports an all-ones quotient
  a_dz_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dz_r) |-> (&out_q_r))
    else $error("zero divisor quotient not all ones");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(out_q_r)
                                          && $stable(out_rem_r)))
    else $error("waiting result changed");

endmodule
